>>> rtl/core/zmhr_pkg.sv
// Package for the ZMODEM header receiver: item types, protocol constants,
// status codes and the CRC-16 and hex digit helper functions.
// No dependencies.
`timescale 1ns / 1ps

package zmhr_pkg;

  // Protocol bytes.
  localparam logic [7:0] ZDLE      = 8'h18;
  localparam logic [7:0] FMT_HEX   = 8'h42;
  localparam logic [7:0] FMT_BIN   = 8'h41;
  localparam logic [7:0] FMT_BIN32 = 8'h43;
  localparam logic [7:0] ESC_XOR   = 8'h40;
  localparam logic [7:0] TERM_LO   = 8'h68;
  localparam logic [7:0] TERM_HI   = 8'h6B;
  localparam logic [7:0] MAX_TYPE  = 8'd12;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Frame layout counts.
  localparam logic [4:0] HEX_DIGITS  = 5'd14;
  localparam logic [4:0] TRAIL_LEN   = 5'd2;
  localparam logic [4:0] BIN_UNITS   = 5'd7;
  localparam logic [4:0] BIN32_UNITS = 5'd5;
  localparam logic [4:0] SKIP_UNITS  = 5'd2;
  localparam logic [4:0] CRC32_UNITS = 5'd4;
  localparam int         HDR_BYTES   = 5;
  localparam logic [2:0] FCRC_HI_POS = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LOST_HUNT = 3'd1;
  localparam logic [2:0] ST_LOST_FMT  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_BAD_HEX   = 3'd4;
  localparam logic [2:0] ST_BIN_PARSE = 3'd5;
  localparam logic [2:0] ST_CRC_BAD   = 3'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_lost;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  header_type;
    logic [7:0]  data0;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [7:0]  data3;
    logic        crc32_mode;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } out_item_t;

  // Bitwise CRC-16 CCITT update over one byte, MSB first.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Hex digit value; 16 marks a character that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end
    return v;
  endfunction

endpackage

>>> rtl/core/zmhr_in_stage.sv
// Input register of the ZMODEM header receiver.
// Holds one accepted item until the parser consumes it. Uses zmhr_pkg.
`timescale 1ns / 1ps

module zmhr_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  zmhr_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               stg_valid,
  output zmhr_pkg::in_item_t stg_item
);
  import zmhr_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign stg_valid = valid_r;
  assign stg_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> rtl/core/zmhr_parser.sv
// Header parser of the ZMODEM header receiver: frame state machine, ZDLE
// unescaping, hex pairing and CRC-16 accumulation. Uses zmhr_pkg.
`timescale 1ns / 1ps

module zmhr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  zmhr_pkg::in_item_t  stg_item,
  output logic                res_valid,
  output zmhr_pkg::out_item_t res_item
);
  import zmhr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_FORMAT, PH_HEX, PH_TRAIL, PH_BIN, PH_BIN_SKIP, PH_BIN32, PH_BIN32_SKIP
  } phase_t;

  typedef enum logic [1:0] {U_NONE, U_BYTE, U_FAIL} unit_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  fpos_r, fpos_nxt;
  logic        esc_r, esc_nxt;
  logic [4:0]  hnib_r, hnib_nxt;
  logic [7:0]  hdr_r [HDR_BYTES];
  logic [7:0]  hdr_nxt [HDR_BYTES];
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [15:0] fcrc_r, fcrc_nxt;
  logic        sticky_r, sticky_nxt;

  logic [7:0]  b;
  logic        lost;
  unit_t       unit;
  logic [7:0]  unit_val;
  logic        unit_esc;
  logic [4:0]  hex_lo;
  logic [7:0]  sv;
  logic [2:0]  sk;
  logic [15:0] rcrc_st, fcrc_st;
  logic        emit_en, emit_hdr;
  logic [2:0]  emit_status;
  logic [15:0] emit_cc, emit_rc;

  assign b    = stg_item.rx_byte;
  assign lost = stg_item.link_lost;

  // Unescaping of one raw item in the binary phases.
  always_comb begin
    unit     = U_BYTE;
    unit_val = b;
    unit_esc = esc_r;
    if (lost) begin
      unit     = U_FAIL;
      unit_esc = 1'b0;
    end else if (esc_r) begin
      unit_esc = 1'b0;
      unit_val = b ^ ESC_XOR;
      if (b >= TERM_LO && b <= TERM_HI) begin
        unit = U_FAIL;
      end
    end else if (b == ZDLE) begin
      unit     = U_NONE;
      unit_esc = 1'b1;
    end
  end

  // Candidate byte store: header entry or received CRC half, with the CRC update.
  always_comb begin
    hex_lo = hex_value(b);
    if (phase_r == PH_HEX) begin
      sv = {hnib_r[3:0], hex_lo[3:0]};
      sk = fpos_r[3:1];
    end else begin
      sv = unit_val;
      sk = fpos_r[2:0];
    end
    rcrc_st = rcrc_r;
    fcrc_st = fcrc_r;
    if (sk < FCRC_HI_POS) begin
      rcrc_st = crc_add(rcrc_r, sv);
    end else if (sk == FCRC_HI_POS) begin
      fcrc_st = {sv, fcrc_r[7:0]};
    end else begin
      fcrc_st = {fcrc_r[15:8], sv};
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    fpos_nxt   = fpos_r;
    esc_nxt    = esc_r;
    hnib_nxt   = hnib_r;
    hdr_nxt    = hdr_r;
    rcrc_nxt   = rcrc_r;
    fcrc_nxt   = fcrc_r;
    sticky_nxt = sticky_r;
    emit_en     = 1'b0;
    emit_hdr    = 1'b0;
    emit_status = ST_OK;
    emit_cc     = 16'h0000;
    emit_rc     = 16'h0000;

    if (fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (lost) begin
            emit_en     = 1'b1;
            emit_status = ST_LOST_HUNT;
          end else if (b == ZDLE) begin
            phase_nxt = PH_FORMAT;
          end
        end
        PH_FORMAT: begin
          if (lost) begin
            emit_en     = 1'b1;
            emit_status = ST_LOST_FMT;
          end else if (b == FMT_HEX || b == FMT_BIN || b == FMT_BIN32) begin
            fpos_nxt = 5'd0;
            esc_nxt  = 1'b0;
            hnib_nxt = 5'd0;
            rcrc_nxt = 16'h0000;
            fcrc_nxt = 16'h0000;
            if (b == FMT_HEX) begin
              phase_nxt = PH_HEX;
            end else if (b == FMT_BIN) begin
              phase_nxt = PH_BIN;
            end else begin
              phase_nxt = PH_BIN32;
            end
          end else begin
            emit_en     = 1'b1;
            emit_status = ST_UNKNOWN;
          end
        end
        PH_HEX: begin
          if (lost) begin
            emit_en     = 1'b1;
            emit_status = ST_BAD_HEX;
          end else if (!fpos_r[0]) begin
            hnib_nxt = hex_lo;
            fpos_nxt = fpos_r + 5'd1;
          end else if (hnib_r[4] || hex_lo[4]) begin
            emit_en     = 1'b1;
            emit_status = ST_BAD_HEX;
          end else begin
            if (sk < FCRC_HI_POS) begin
              hdr_nxt[sk] = sv;
            end
            rcrc_nxt = rcrc_st;
            fcrc_nxt = fcrc_st;
            fpos_nxt = fpos_r + 5'd1;
            if (fpos_nxt >= HEX_DIGITS) begin
              phase_nxt = PH_TRAIL;
              fpos_nxt  = 5'd0;
            end
          end
        end
        PH_TRAIL: begin
          fpos_nxt = fpos_r + 5'd1;
          if (fpos_nxt >= TRAIL_LEN) begin
            emit_en     = 1'b1;
            emit_cc     = rcrc_r;
            emit_rc     = fcrc_r;
            emit_hdr    = (rcrc_r == fcrc_r);
            emit_status = (rcrc_r == fcrc_r) ? ST_OK : ST_CRC_BAD;
          end
        end
        PH_BIN, PH_BIN32: begin
          esc_nxt = unit_esc;
          if (unit == U_FAIL) begin
            emit_en     = 1'b1;
            emit_status = ST_BIN_PARSE;
          end else if (unit == U_BYTE) begin
            if (sk < FCRC_HI_POS) begin
              hdr_nxt[sk] = sv;
            end
            rcrc_nxt = rcrc_st;
            fcrc_nxt = fcrc_st;
            fpos_nxt = fpos_r + 5'd1;
            if (phase_r == PH_BIN32) begin
              if (fpos_nxt >= BIN32_UNITS) begin
                phase_nxt = PH_BIN32_SKIP;
                fpos_nxt  = 5'd0;
              end
            end else if (fpos_nxt >= BIN_UNITS) begin
              if (rcrc_st == fcrc_st) begin
                emit_en  = 1'b1;
                emit_hdr = 1'b1;
                emit_cc  = rcrc_st;
                emit_rc  = fcrc_st;
              end else if (hdr_nxt[0] <= MAX_TYPE) begin
                // A CRC mismatch on a low type means the sender really sends
                // CRC-32; swallow the two extra check bytes.
                phase_nxt = PH_BIN_SKIP;
                fpos_nxt  = 5'd0;
              end else begin
                emit_en     = 1'b1;
                emit_status = ST_CRC_BAD;
                emit_cc     = rcrc_st;
                emit_rc     = fcrc_st;
              end
            end
          end
        end
        PH_BIN_SKIP, PH_BIN32_SKIP: begin
          esc_nxt = unit_esc;
          if (unit != U_NONE) begin
            fpos_nxt = fpos_r + 5'd1;
            if (phase_r == PH_BIN_SKIP) begin
              if (fpos_nxt >= SKIP_UNITS) begin
                sticky_nxt = 1'b1;
                emit_en    = 1'b1;
                emit_hdr   = 1'b1;
                emit_cc    = rcrc_r;
                emit_rc    = fcrc_r;
              end
            end else if (fpos_nxt >= CRC32_UNITS) begin
              emit_en = 1'b1;
              if (hdr_r[0] > MAX_TYPE) begin
                emit_status = ST_UNKNOWN;
              end else begin
                sticky_nxt = 1'b1;
                emit_hdr   = 1'b1;
                emit_cc    = rcrc_r;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase

      if (emit_en) begin
        phase_nxt = PH_HUNT;
        fpos_nxt  = 5'd0;
        esc_nxt   = 1'b0;
      end
    end
  end

  always_comb begin
    res_valid                 = emit_en;
    res_item.status           = emit_status;
    res_item.header_type      = emit_hdr ? hdr_nxt[0] : 8'h00;
    res_item.data0            = emit_hdr ? hdr_nxt[1] : 8'h00;
    res_item.data1            = emit_hdr ? hdr_nxt[2] : 8'h00;
    res_item.data2            = emit_hdr ? hdr_nxt[3] : 8'h00;
    res_item.data3            = emit_hdr ? hdr_nxt[4] : 8'h00;
    res_item.crc32_mode       = sticky_nxt;
    res_item.computed_crc     = emit_cc;
    res_item.received_crc     = emit_rc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      fpos_r   <= 5'd0;
      esc_r    <= 1'b0;
      hnib_r   <= 5'd0;
      rcrc_r   <= 16'h0000;
      fcrc_r   <= 16'h0000;
      sticky_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      fpos_r   <= fpos_nxt;
      esc_r    <= esc_nxt;
      hnib_r   <= hnib_nxt;
      rcrc_r   <= rcrc_nxt;
      fcrc_r   <= fcrc_nxt;
      sticky_r <= sticky_nxt;
    end
  end

  // Header bytes are payload: no reset, every frame writes them before use.
  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

>>> rtl/core/zmhr_out_stage.sv
// Result register of the ZMODEM header receiver.
// Holds one result item until the downstream side takes it. Uses zmhr_pkg.
`timescale 1ns / 1ps

module zmhr_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  output logic                can_load,
  input  logic                load,
  input  zmhr_pkg::out_item_t res_item,
  output logic                out_valid,
  input  logic                out_ready,
  output zmhr_pkg::out_item_t out_item
);
  import zmhr_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load && can_load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      item_r <= res_item;
    end
  end

endmodule

>>> rtl/core/zmodem_header_receiver_top.sv
// Top level of the ZMODEM header receiver.
// Instantiates zmhr_in_stage, zmhr_parser and zmhr_out_stage; uses zmhr_pkg.
//
//   Channel   Ports                           Moves
//   input     in_valid, in_ready, in_item     one link byte or link-lost mark
//   result    out_valid, out_ready, out_item  one header or error status
//
// An item is registered on acceptance and then parsed by the frame state machine,
// unescaper and CRC-16 byte update; any result goes to the result register, which drives out_valid.
// One item is accepted per cycle while the result register is free or draining.
// Reset (rst_n low at an edge) restarts the ZDLE hunt, clears the CRC-32 flag and
// empties both stages. A result-side stall holds the parser; the input register
// takes one more item, then in_ready stays low until the stall clears.
`timescale 1ns / 1ps

module zmodem_header_receiver_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  zmhr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output zmhr_pkg::out_item_t out_item
);
  import zmhr_pkg::*;

  logic      stg_valid;
  in_item_t  stg_item;
  logic      can_load;
  logic      fire;
  logic      res_valid;
  out_item_t res_item;

  // The staged item is parsed whenever the result register can take whatever
  // the parser produces in this cycle.
  assign fire = stg_valid && can_load;

  zmhr_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .advance   (can_load),
    .stg_valid (stg_valid),
    .stg_item  (stg_item)
  );

  zmhr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .stg_item  (stg_item),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  zmhr_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .can_load  (can_load),
    .load      (res_valid),
    .res_item  (res_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
